// File: rtl/core/kdl_pkg.sv
// Shared widths, operation and status codes, and sequencer states for the keyed deque list.
package kdl_pkg;

    localparam int FUNC_W   = 3;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [FUNC_W-1:0] FUNC_INSERT    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEL_KEY   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_DEL_FIRST = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DEL_LAST  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DUMP      = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT_RD,
        ST_SHIFT,
        ST_DUMP,
        ST_RESP
    } state_t;

endpackage

// File: rtl/core/keyed_deque_list_top.sv
// Keyed deque list: ring-held ordered key list with search, shift and dump sequencer.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | s_valid s_ready s_func s_key            | in
//  result  | m_valid m_ready m_value m_status        | out
//          | m_count m_last                          |
//
// Insert, delete first, delete last and unknown codes: result registered from the response state.
// Delete key: one read a cycle through the key store to find the key, then one slot moved a
// cycle to close the gap; the result is then registered from the response state.
// Dump: one element a cycle from the store while the result side keeps up; the last element
// carries m_last and returns the sequencer to idle.
// Reset empties the list at once; the key store itself has no clearing pass.
// s_ready is high only between transactions; a stalled result holds the sequencer.
module keyed_deque_list_top #(
    parameter int CAPACITY = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [kdl_pkg::FUNC_W-1:0]          s_func,
    input  logic signed [kdl_pkg::KEY_W-1:0]    s_key,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [kdl_pkg::KEY_W-1:0]    m_value,
    output logic [kdl_pkg::STATUS_W-1:0]        m_status,
    output logic [kdl_pkg::COUNT_W-1:0]         m_count,
    output logic                                m_last
);
    import kdl_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
        slot_inc = (s == AW'(CAPACITY - 1)) ? '0 : s + AW'(1);
    endfunction

    function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
        slot_dec = (s == '0) ? AW'(CAPACITY - 1) : s - AW'(1);
    endfunction

    logic [KEY_W-1:0] mem [CAPACITY];

    state_t              state_reg, state_next;
    logic [AW-1:0]       front_reg, front_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [CW-1:0]       iss_pos_reg, iss_pos_next;
    logic [AW-1:0]       iss_slot_reg, iss_slot_next;
    logic                live_reg, live_next;
    logic [CW-1:0]       cmp_pos_reg, cmp_pos_next;
    logic [AW-1:0]       cmp_slot_reg, cmp_slot_next;
    logic [AW-1:0]       wr_slot_reg, wr_slot_next;
    logic [AW-1:0]       rd_slot_reg, rd_slot_next;
    logic [CW-1:0]       rem_reg, rem_next;
    logic [KEY_W-1:0]    rd_data_reg;

    logic                m_valid_reg, m_valid_next;
    logic [KEY_W-1:0]    m_value_reg, m_value_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [CW-1:0]       m_count_reg, m_count_next;
    logic                m_last_reg, m_last_next;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [KEY_W-1:0]    mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;

    logic                accept;
    logic                out_free;
    logic                hit;
    logic                at_end;
    logic                issue;
    logic                load;
    logic [CW-1:0]       count_m1;
    logic [CW-1:0]       rem_hit;

    assign accept   = s_valid && (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign count_m1 = count_reg - CW'(1);
    assign hit      = live_reg && (rd_data_reg == key_reg);
    assign at_end   = live_reg && (cmp_pos_reg == count_m1);
    assign rem_hit  = count_m1 - cmp_pos_reg;
    assign load     = live_reg && out_free;
    assign issue    = (iss_pos_reg < count_reg) && (!live_reg || out_free);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            live_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            count_reg   <= count_next;
            live_reg    <= live_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        status_reg   <= status_next;
        iss_pos_reg  <= iss_pos_next;
        iss_slot_reg <= iss_slot_next;
        cmp_pos_reg  <= cmp_pos_next;
        cmp_slot_reg <= cmp_slot_next;
        wr_slot_reg  <= wr_slot_next;
        rd_slot_reg  <= rd_slot_next;
        rem_reg      <= rem_next;
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
        m_last_reg   <= m_last_next;
    end

    always_comb begin
        state_next    = state_reg;
        front_next    = front_reg;
        count_next    = count_reg;
        key_next      = key_reg;
        status_next   = status_reg;
        iss_pos_next  = iss_pos_reg;
        iss_slot_next = iss_slot_reg;
        live_next     = live_reg;
        cmp_pos_next  = cmp_pos_reg;
        cmp_slot_next = cmp_slot_reg;
        wr_slot_next  = wr_slot_reg;
        rd_slot_next  = rd_slot_reg;
        rem_next      = rem_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        m_count_next  = m_count_reg;
        m_last_next   = m_last_reg;
        mem_we        = 1'b0;
        mem_waddr     = wr_slot_reg;
        mem_wdata     = rd_data_reg;
        mem_re        = 1'b0;
        mem_raddr     = rd_slot_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    status_next   = STATUS_OK;
                    key_next      = s_key;
                    iss_pos_next  = '0;
                    iss_slot_next = front_reg;
                    live_next     = 1'b0;
                    state_next    = ST_RESP;
                    unique case (s_func)
                        FUNC_INSERT: begin
                            if (count_reg == CW'(CAPACITY)) begin
                                status_next = STATUS_FULL;
                            end else begin
                                front_next = slot_dec(front_reg);
                                count_next = count_reg + CW'(1);
                                mem_we     = 1'b1;
                                mem_waddr  = slot_dec(front_reg);
                                mem_wdata  = s_key;
                            end
                        end
                        FUNC_DEL_KEY: begin
                            if (count_reg == '0) begin
                                status_next = STATUS_EMPTY;
                            end else begin
                                state_next = ST_SEARCH;
                            end
                        end
                        FUNC_DEL_FIRST: begin
                            if (count_reg == '0) begin
                                status_next = STATUS_EMPTY;
                            end else begin
                                front_next = slot_inc(front_reg);
                                count_next = count_m1;
                            end
                        end
                        FUNC_DEL_LAST: begin
                            if (count_reg == '0) begin
                                status_next = STATUS_EMPTY;
                            end else begin
                                count_next = count_m1;
                            end
                        end
                        FUNC_DUMP: begin
                            if (count_reg == '0) begin
                                status_next = STATUS_EMPTY;
                            end else begin
                                state_next = ST_DUMP;
                            end
                        end
                        default: begin
                            status_next = STATUS_OK;
                        end
                    endcase
                end
            end

            ST_SEARCH: begin
                if (hit) begin
                    wr_slot_next = cmp_slot_reg;
                    rd_slot_next = slot_inc(cmp_slot_reg);
                    rem_next     = rem_hit;
                    live_next    = 1'b0;
                    if (rem_hit == '0) begin
                        count_next  = count_m1;
                        status_next = STATUS_OK;
                        state_next  = ST_RESP;
                    end else begin
                        state_next = ST_SHIFT_RD;
                    end
                end else if (at_end) begin
                    live_next   = 1'b0;
                    status_next = STATUS_NOT_FOUND;
                    state_next  = ST_RESP;
                end else begin
                    // compare uses the registered read data; keep one read in flight
                    mem_re        = 1'b1;
                    mem_raddr     = iss_slot_reg;
                    live_next     = 1'b1;
                    cmp_pos_next  = iss_pos_reg;
                    cmp_slot_next = iss_slot_reg;
                    iss_pos_next  = iss_pos_reg + CW'(1);
                    iss_slot_next = slot_inc(iss_slot_reg);
                end
            end

            ST_SHIFT_RD: begin
                mem_re       = 1'b1;
                mem_raddr    = rd_slot_reg;
                rd_slot_next = slot_inc(rd_slot_reg);
                state_next   = ST_SHIFT;
            end

            ST_SHIFT: begin
                // move the entry behind one place forward, fetch the next in the same cycle
                mem_we       = 1'b1;
                mem_waddr    = wr_slot_reg;
                mem_wdata    = rd_data_reg;
                wr_slot_next = slot_inc(wr_slot_reg);
                rem_next     = rem_reg - CW'(1);
                if (rem_reg == CW'(1)) begin
                    count_next  = count_m1;
                    status_next = STATUS_OK;
                    state_next  = ST_RESP;
                end else begin
                    mem_re       = 1'b1;
                    mem_raddr    = rd_slot_reg;
                    rd_slot_next = slot_inc(rd_slot_reg);
                end
            end

            ST_DUMP: begin
                if (load) begin
                    m_valid_next  = 1'b1;
                    m_value_next  = rd_data_reg;
                    m_status_next = STATUS_OK;
                    m_count_next  = count_reg;
                    m_last_next   = (cmp_pos_reg == count_m1);
                    live_next     = 1'b0;
                    if (cmp_pos_reg == count_m1) begin
                        state_next = ST_IDLE;
                    end
                end
                if (issue) begin
                    mem_re        = 1'b1;
                    mem_raddr     = iss_slot_reg;
                    live_next     = 1'b1;
                    cmp_pos_next  = iss_pos_reg;
                    iss_pos_next  = iss_pos_reg + CW'(1);
                    iss_slot_next = slot_inc(iss_slot_reg);
                end
            end

            ST_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_value_next  = '0;
                    m_status_next = status_reg;
                    m_count_next  = count_reg;
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_value  = m_value_reg;
    assign m_status = m_status_reg;
    assign m_count  = COUNT_W'(m_count_reg);
    assign m_last   = m_last_reg;

endmodule

// File: rtl/core/kdl_checker.sv
// Port-level checks on the keyed deque list results, bound to the top level.
module kdl_checker #(
    parameter int CAPACITY = 64
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic signed [kdl_pkg::KEY_W-1:0] m_value,
    input logic [kdl_pkg::STATUS_W-1:0]     m_status,
    input logic [kdl_pkg::COUNT_W-1:0]      m_count,
    input logic                             m_last
);
    import kdl_pkg::*;

    // hold a stalled result transaction
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_status)
            && $stable(m_count) && $stable(m_last))
        else $error("result changed while stalled");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STATUS_FULL) |-> m_count == COUNT_W'(CAPACITY) && m_last)
        else $error("full status with list not full");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STATUS_EMPTY) |-> m_count == '0 && m_value == '0 && m_last)
        else $error("empty status with bad result fields");

    a_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_status == STATUS_OK && m_count != '0)
        else $error("dump run result with bad status");

    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_count <= COUNT_W'(CAPACITY))
        else $error("count beyond capacity");

endmodule

bind keyed_deque_list_top kdl_checker #(.CAPACITY(CAPACITY)) u_kdl_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench for the keyed deque list against a ring-list predictor.
`timescale 1ns / 100ps

module testbench;

    import kdl_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int SLOT_W       = $clog2(CAPACITY);
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
    localparam int PRINT_LIMIT  = 50;

    // Codes the block does not define; they must leave the list untouched.
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

    typedef struct {
        logic signed [KEY_W-1:0]  value;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_W-1:0]       count;
        logic                     last;
    } list_result_t;

    logic                       aclk    = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [FUNC_W-1:0]          s_func  = '0;
    logic signed [KEY_W-1:0]    s_key   = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [KEY_W-1:0]    m_value;
    logic [STATUS_W-1:0]        m_status;
    logic [COUNT_W-1:0]         m_count;
    logic                       m_last;

    // Predicted list: ring of keys, slot of the first element, number held.
    logic signed [KEY_W-1:0]        list_keys [CAPACITY];
    logic [SLOT_W-1:0]              list_front;
    logic [COUNT_W-1:0]             list_count;

    list_result_t   pending_results [$];
    bit             stalls_on;
    int             error_count;
    int             ops_sent;
    int             results_checked;
    int             peak_count;
    int             status_seen [4];

    keyed_deque_list_top #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_func   (s_func),
        .s_key    (s_key),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_value  (m_value),
        .m_status (m_status),
        .m_count  (m_count),
        .m_last   (m_last)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    task automatic report_error(input string msg);
        if (error_count < PRINT_LIMIT) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
        error_count++;
    endtask

    function automatic logic [SLOT_W-1:0] slot_at(input int pos);
        return SLOT_W'((int'(list_front) + pos) % CAPACITY);
    endfunction

    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 93) return $urandom_range(3, 8);
        return $urandom_range(12, 40);
    endfunction

    task automatic push_result(input logic signed [KEY_W-1:0] value,
                               input logic [STATUS_W-1:0] status, input logic last);
        list_result_t r;
        r.value  = value;
        r.status = status;
        r.count  = list_count;
        r.last   = last;
        pending_results.push_back(r);
    endtask

    task automatic predict_list_op(input logic [FUNC_W-1:0] func,
                                   input logic signed [KEY_W-1:0] key);
        logic [STATUS_W-1:0] st;
        bit hit;
        st  = STATUS_OK;
        hit = 1'b0;
        case (func)
            FUNC_INSERT: begin
                if (list_count >= CAPACITY) begin
                    st = STATUS_FULL;
                end else begin
                    list_front = slot_at(CAPACITY - 1);
                    list_keys[list_front] = key;
                    list_count++;
                end
            end
            FUNC_DEL_KEY: begin
                if (list_count == 0) begin
                    st = STATUS_EMPTY;
                end else begin
                    st = STATUS_NOT_FOUND;
                    for (int i = 0; i < list_count && !hit; i++) begin
                        if (list_keys[slot_at(i)] == key) begin
                            // close the gap: everything behind moves one place forward
                            for (int j = i; j + 1 < list_count; j++) begin
                                list_keys[slot_at(j)] = list_keys[slot_at(j + 1)];
                            end
                            list_count--;
                            st  = STATUS_OK;
                            hit = 1'b1;
                        end
                    end
                end
            end
            FUNC_DEL_FIRST: begin
                if (list_count == 0) begin
                    st = STATUS_EMPTY;
                end else begin
                    list_front = slot_at(1);
                    list_count--;
                end
            end
            FUNC_DEL_LAST: begin
                if (list_count == 0) st = STATUS_EMPTY;
                else list_count--;
            end
            FUNC_DUMP: begin
                if (list_count == 0) begin
                    push_result('0, STATUS_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < list_count; i++) begin
                        push_result(list_keys[slot_at(i)], STATUS_OK, i + 1 == list_count);
                    end
                end
            end
            default: ;
        endcase
        if (func != FUNC_DUMP) push_result('0, st, 1'b1);
        if (list_count > peak_count) peak_count = list_count;
    endtask

    // Enter between falling edges; return just after the accepting rising edge.
    task automatic send_op(input logic [FUNC_W-1:0] func, input logic signed [KEY_W-1:0] key);
        int gap;
        gap = (stalls_on && $urandom_range(0, 2) == 0) ? gap_cycles() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_func  = func;
        s_key   = key;
        do @(posedge aclk); while (!s_ready);
        predict_list_op(func, key);
        ops_sent++;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4 && list_count != 0) return list_keys[slot_at($urandom_range(0, list_count - 1))];
        if (r < 6) begin
            case ($urandom_range(0, 6))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return 32'sd1;
                3: return -32'sd1;
                4: return 32'sd2;
                5: return -32'sd2;
                default: return '0;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [FUNC_W-1:0] pick_func();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return FUNC_INSERT;
        if (r < 55) return FUNC_DEL_KEY;
        if (r < 67) return FUNC_DEL_FIRST;
        if (r < 79) return FUNC_DEL_LAST;
        if (r < 91) return FUNC_DUMP;
        return FUNC_W'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
    endfunction

    task automatic test_empty_list();
        send_op(FUNC_DEL_KEY, '0);
        send_op(FUNC_DEL_FIRST, $urandom);
        send_op(FUNC_DEL_LAST, $urandom);
        send_op(FUNC_DUMP, $urandom);
        for (int f = FUNC_SPARE_LO; f <= FUNC_SPARE_HI; f++) send_op(FUNC_W'(f), $urandom);
        wait_idle();
    endtask

    task automatic test_basic_ops();
        send_op(FUNC_INSERT, 32'sh8000_0000);
        send_op(FUNC_INSERT, 32'sh7FFF_FFFF);
        send_op(FUNC_INSERT, '0);
        send_op(FUNC_INSERT, -32'sd1);
        send_op(FUNC_INSERT, 32'sh5555_5555);
        send_op(FUNC_INSERT, 32'shAAAA_AAAA);
        send_op(FUNC_INSERT, '0);
        send_op(FUNC_DUMP, $urandom);
        // middle element, then the front copy of a duplicated key
        send_op(FUNC_DEL_KEY, -32'sd1);
        send_op(FUNC_DEL_KEY, '0);
        send_op(FUNC_DEL_KEY, 32'sd12345);
        send_op(FUNC_DEL_FIRST, $urandom);
        send_op(FUNC_DEL_LAST, $urandom);
        send_op(FUNC_SPARE_HI, $urandom);
        send_op(FUNC_DUMP, $urandom);
        wait_idle();
    endtask

    task automatic test_random_mix(input int n_ops, input bit with_stalls);
        stalls_on = with_stalls;
        repeat (n_ops) send_op(pick_func(), pick_key());
        wait_idle();
    endtask

    task automatic test_fill_and_drain();
        stalls_on = 1'b1;
        while (list_count < CAPACITY) begin
            if ($urandom_range(0, 19) == 0) send_op(FUNC_DUMP, $urandom);
            else send_op(FUNC_INSERT, pick_key());
        end
        repeat (3) send_op(FUNC_INSERT, $urandom);
        send_op(FUNC_DUMP, $urandom);
        // longest search: the key held at the back
        send_op(FUNC_DEL_KEY, list_keys[slot_at(list_count - 1)]);
        send_op(FUNC_DEL_KEY, $urandom);
        while (list_count < CAPACITY) send_op(FUNC_INSERT, pick_key());
        send_op(FUNC_DUMP, $urandom);
        while (list_count > 0) begin
            case ($urandom_range(0, 2))
                0: send_op(FUNC_DEL_FIRST, $urandom);
                1: send_op(FUNC_DEL_LAST, $urandom);
                default: send_op(FUNC_DEL_KEY, pick_key());
            endcase
        end
        send_op(FUNC_DUMP, $urandom);
        send_op(FUNC_DEL_KEY, pick_key());
        wait_idle();
    endtask

    initial begin : result_ready_drive
        int n;
        forever begin
            @(negedge aclk);
            if (stalls_on && $urandom_range(0, 3) == 0) begin
                n = gap_cycles();
                m_ready = 1'b0;
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        list_result_t want;
        if (aresetn && m_valid && m_ready) begin
            status_seen[m_status]++;
            if (pending_results.size() == 0) begin
                report_error($sformatf("result with none outstanding: value %0d status %0d",
                                       m_value, m_status));
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_value !== want.value)
                    report_error($sformatf("value %0d, wanted %0d", m_value, want.value));
                if (m_status !== want.status)
                    report_error($sformatf("status %0d, wanted %0d", m_status, want.status));
                if (m_count !== want.count)
                    report_error($sformatf("count %0d, wanted %0d", m_count, want.count));
                if (m_last !== want.last)
                    report_error($sformatf("last %0b, wanted %0b", m_last, want.last));
            end
        end
    end

    // Abort when no transaction moves on either channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : main_sequence
        list_front      = '0;
        list_count      = '0;
        stalls_on       = 1'b0;
        error_count     = 0;
        ops_sent        = 0;
        results_checked = 0;
        peak_count      = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_empty_list();
        test_basic_ops();
        test_random_mix(50, 1'b0);
        test_fill_and_drain();
        test_random_mix(80, 1'b1);

        stalls_on = 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0)
            report_error($sformatf("%0d results never arrived", pending_results.size()));

        $display("Run covered %0d operations and %0d checked results, peak occupancy %0d of %0d",
                 ops_sent, results_checked, peak_count, CAPACITY);
        $display("Statuses seen: ok %0d, not found %0d, empty %0d, full %0d",
                 status_seen[STATUS_OK], status_seen[STATUS_NOT_FOUND],
                 status_seen[STATUS_EMPTY], status_seen[STATUS_FULL]);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/kdl_pkg.sv
rtl/core/keyed_deque_list_top.sv
rtl/core/kdl_checker.sv
tb/testbench.sv
